>>> rtl/lct_pkg.sv
`timescale 1ns / 1ps

package lct_pkg;

	localparam int LBA_W      = 32;
	localparam int GEO_W      = 8;
	localparam int CYL_W      = 16;
	localparam int DIV_BITS   = 4;
	localparam int DIV_STAGES = LBA_W / DIV_BITS;

	typedef enum logic [1:0] {
		CMD_LBA_TO_CHS = 2'd0,
		CMD_CHS_TO_LBA = 2'd1,
		CMD_CHS_TO_CHS = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		REG_SRC_HEADS   = 2'd0,
		REG_SRC_SECTORS = 2'd1,
		REG_DST_HEADS   = 2'd2,
		REG_DST_SECTORS = 2'd3
	} reg_idx_t;

	// Sideband that travels with a word through the dividers.
	typedef struct packed {
		logic [1:0]       cmd;
		logic [LBA_W-1:0] lba;
		logic [GEO_W-1:0] sector;
	} side_t;

	// Four restoring division steps: remainder in upper bits, quotient bits low.
	function automatic logic [GEO_W+DIV_BITS-1:0] div_step(
		input logic [GEO_W-1:0]    rem_in,
		input logic [DIV_BITS-1:0] nib,
		input logic [GEO_W-1:0]    den
	);
		logic [GEO_W-1:0]    r;
		logic [GEO_W:0]      t;
		logic [DIV_BITS-1:0] q;
		r = rem_in;
		q = '0;
		for (int j = DIV_BITS - 1; j >= 0; j--) begin
			t = {r, nib[j]};
			if (t >= {1'b0, den}) begin
				t    = t - {1'b0, den};
				q[j] = 1'b1;
			end
			r = t[GEO_W-1:0];
		end
		return {r, q};
	endfunction

endpackage

>>> rtl/lba_chs_address_translator.sv
`timescale 1ns / 1ps

// LBA / CHS address translator. Each input word carries a command: LBA to CHS
// in the destination geometry, CHS in the source geometry to LBA, or both
// chained. The block is a 19-stage pipeline: two multiply stages form the LBA,
// two 8-stage dividers (four quotient bits per stage) split it by sectors per
// track and then by heads, and one output register holds the result word. A
// new word is taken every cycle while the output side does not stall; each
// word's result is presented from the output register after the word has
// passed both multiply stages and both dividers. Empty stages close up while
// the output is held, so input is still taken until the pipeline fills.
// Geometry registers sit on an APB-style port at byte addresses 0, 4, 8 and 12
// (source heads, source sectors, destination heads, destination sectors) and
// should be written only while no word is in flight. A geometry value of zero
// is treated as one. Cylinders above 65535 are truncated and flagged.
module lba_chs_address_translator (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [31:0] lba_in,
	input  logic [15:0] cylinder_in,
	input  logic [7:0]  head_in,
	input  logic [7:0]  sector_in,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] lba_out,
	output logic [15:0] cylinder_out,
	output logic [7:0]  head_out,
	output logic [7:0]  sector_out,
	output logic        cylinder_overflow
);
	import lct_pkg::*;

	logic [GEO_W-1:0] src_heads_q, src_sectors_q, dst_heads_q, dst_sectors_q;
	logic [GEO_W-1:0] src_heads, src_spt, dst_heads, dst_spt;
	reg_idx_t         idx;

	// The register index comes from the word address; byte bits are ignored.
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_heads_q   <= 8'd16;
			src_sectors_q <= 8'd63;
			dst_heads_q   <= 8'd255;
			dst_sectors_q <= 8'd63;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_SRC_HEADS:   src_heads_q   <= pwdata[GEO_W-1:0];
				REG_SRC_SECTORS: src_sectors_q <= pwdata[GEO_W-1:0];
				REG_DST_HEADS:   dst_heads_q   <= pwdata[GEO_W-1:0];
				REG_DST_SECTORS: dst_sectors_q <= pwdata[GEO_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_SRC_HEADS:   prdata = {24'd0, src_heads_q};
			REG_SRC_SECTORS: prdata = {24'd0, src_sectors_q};
			REG_DST_HEADS:   prdata = {24'd0, dst_heads_q};
			REG_DST_SECTORS: prdata = {24'd0, dst_sectors_q};
			default:         prdata = '0;
		endcase
	end

	// A zero geometry value behaves as one, which also keeps the dividers safe.
	assign src_heads = (src_heads_q   == '0) ? GEO_W'(1) : src_heads_q;
	assign src_spt   = (src_sectors_q == '0) ? GEO_W'(1) : src_sectors_q;
	assign dst_heads = (dst_heads_q   == '0) ? GEO_W'(1) : dst_heads_q;
	assign dst_spt   = (dst_sectors_q == '0) ? GEO_W'(1) : dst_sectors_q;

	// CHS to LBA front end; command 0 passes its LBA straight through.
	logic             m_valid, m_ready;
	logic [1:0]       m_cmd;
	logic [LBA_W-1:0] m_lba;

	lct_mul u_mul (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.lba_in      (lba_in),
		.cylinder_in (cylinder_in),
		.head_in     (head_in),
		.sector_in   (sector_in),
		.heads       (src_heads),
		.spt         (src_spt),
		.out_valid   (m_valid),
		.out_ready   (m_ready),
		.out_cmd     (m_cmd),
		.out_lba     (m_lba)
	);

	// First divider: track = lba / spt, sector = lba mod spt + 1.
	side_t            d1_side_in, d1_side;
	logic             d1_valid, d1_ready;
	logic [LBA_W-1:0] d1_quo;
	logic [GEO_W-1:0] d1_rem;

	assign d1_side_in = '{cmd: m_cmd, lba: m_lba, sector: '0};

	lct_div u_div_spt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (m_valid),
		.in_ready  (m_ready),
		.num       (m_lba),
		.den       (dst_spt),
		.side      (d1_side_in),
		.out_valid (d1_valid),
		.out_ready (d1_ready),
		.quo       (d1_quo),
		.rem       (d1_rem),
		.out_side  (d1_side)
	);

	// Second divider: cylinder = track / heads, head = track mod heads.
	side_t            d2_side_in, d2_side;
	logic             d2_valid, d2_ready;
	logic [LBA_W-1:0] d2_quo;
	logic [GEO_W-1:0] d2_rem;

	assign d2_side_in = '{cmd: d1_side.cmd, lba: d1_side.lba, sector: d1_rem + GEO_W'(1)};

	lct_div u_div_heads (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d1_valid),
		.in_ready  (d1_ready),
		.num       (d1_quo),
		.den       (dst_heads),
		.side      (d2_side_in),
		.out_valid (d2_valid),
		.out_ready (d2_ready),
		.quo       (d2_quo),
		.rem       (d2_rem),
		.out_side  (d2_side)
	);

	// Output register: shapes the result word by command.
	logic             out_v_q;
	logic [LBA_W-1:0] lba_q;
	logic [CYL_W-1:0] cyl_q;
	logic [GEO_W-1:0] head_q, sec_q;
	logic             ovf_q;

	assign d2_ready = !out_v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (d2_ready) begin
			out_v_q <= d2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (d2_ready && d2_valid) begin
			case (d2_side.cmd) inside
				CMD_LBA_TO_CHS, CMD_CHS_TO_CHS: begin
					lba_q  <= d2_side.lba;
					cyl_q  <= d2_quo[CYL_W-1:0];
					head_q <= d2_rem;
					sec_q  <= d2_side.sector;
					ovf_q  <= |d2_quo[LBA_W-1:CYL_W];
				end
				CMD_CHS_TO_LBA: begin
					lba_q  <= d2_side.lba;
					cyl_q  <= '0;
					head_q <= '0;
					sec_q  <= '0;
					ovf_q  <= 1'b0;
				end
				default: begin
					lba_q  <= '0;
					cyl_q  <= '0;
					head_q <= '0;
					sec_q  <= '0;
					ovf_q  <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid         = out_v_q;
	assign lba_out           = lba_q;
	assign cylinder_out      = cyl_q;
	assign head_out          = head_q;
	assign sector_out        = sec_q;
	assign cylinder_overflow = ovf_q;

endmodule

>>> rtl/lct_mul.sv
`timescale 1ns / 1ps

module lct_mul (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                cmd,
	input  logic [lct_pkg::LBA_W-1:0] lba_in,
	input  logic [lct_pkg::CYL_W-1:0] cylinder_in,
	input  logic [lct_pkg::GEO_W-1:0] head_in,
	input  logic [lct_pkg::GEO_W-1:0] sector_in,
	input  logic [lct_pkg::GEO_W-1:0] heads,
	input  logic [lct_pkg::GEO_W-1:0] spt,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                out_cmd,
	output logic [lct_pkg::LBA_W-1:0] out_lba
);
	import lct_pkg::*;

	localparam int T_W = CYL_W + GEO_W + 1;

	logic             v_s1, v_s2, rdy_s1, rdy_s2;
	logic [1:0]       cmd_s1, cmd_s2;
	logic [LBA_W-1:0] lba_s1, lba_s2;
	logic [T_W-1:0]   trk_s1;
	logic [GEO_W-1:0] sec_s1;
	logic [LBA_W-1:0] calc;

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Track index c * heads + h, then times sectors per track plus s - 1.
	assign calc = LBA_W'(LBA_W'(trk_s1) * LBA_W'(spt)) + LBA_W'(sec_s1) - LBA_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			cmd_s1 <= cmd;
			lba_s1 <= lba_in;
			trk_s1 <= T_W'(T_W'(cylinder_in) * T_W'(heads)) + T_W'(head_in);
			sec_s1 <= sector_in;
		end
		if (rdy_s2 && v_s1) begin
			cmd_s2 <= cmd_s1;
			lba_s2 <= (cmd_s1 == CMD_LBA_TO_CHS) ? lba_s1 : calc;
		end
	end

	assign out_valid = v_s2;
	assign out_cmd   = cmd_s2;
	assign out_lba   = lba_s2;

endmodule

>>> rtl/lct_div.sv
`timescale 1ns / 1ps

module lct_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [lct_pkg::LBA_W-1:0] num,
	input  logic [lct_pkg::GEO_W-1:0] den,
	input  lct_pkg::side_t            side,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [lct_pkg::LBA_W-1:0] quo,
	output logic [lct_pkg::GEO_W-1:0] rem,
	output lct_pkg::side_t            out_side
);
	import lct_pkg::*;

	logic [DIV_STAGES-1:0] v_s;
	logic [DIV_STAGES-1:0] rdy;
	logic [LBA_W-1:0]      num_s  [DIV_STAGES];
	logic [GEO_W-1:0]      rem_s  [DIV_STAGES];
	side_t                 side_s [DIV_STAGES];

	always_comb begin
		rdy[DIV_STAGES-1] = !v_s[DIV_STAGES-1] || out_ready;
		for (int i = DIV_STAGES - 2; i >= 0; i--) begin
			rdy[i] = !v_s[i] || rdy[i+1];
		end
	end

	assign in_ready = rdy[0];

	// Each stage retires four quotient bits; the numerator register fills with
	// quotient bits from the bottom as dividend bits leave at the top.
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic                      src_v;
		logic [LBA_W-1:0]          src_num;
		logic [GEO_W-1:0]          src_rem;
		side_t                     src_side;
		logic [GEO_W+DIV_BITS-1:0] step;

		if (g == 0) begin : g_first
			assign src_v    = in_valid;
			assign src_num  = num;
			assign src_rem  = '0;
			assign src_side = side;
		end else begin : g_next
			assign src_v    = v_s[g-1];
			assign src_num  = num_s[g-1];
			assign src_rem  = rem_s[g-1];
			assign src_side = side_s[g-1];
		end

		assign step = div_step(src_rem, src_num[LBA_W-1 -: DIV_BITS], den);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (rdy[g]) begin
				v_s[g] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[g] && src_v) begin
				num_s[g]  <= {src_num[LBA_W-DIV_BITS-1:0], step[DIV_BITS-1:0]};
				rem_s[g]  <= step[GEO_W+DIV_BITS-1:DIV_BITS];
				side_s[g] <= src_side;
			end
		end
	end

	assign out_valid = v_s[DIV_STAGES-1];
	assign quo       = num_s[DIV_STAGES-1];
	assign rem       = rem_s[DIV_STAGES-1];
	assign out_side  = side_s[DIV_STAGES-1];

endmodule
